// File: rtl/core/drod_pkg.sv
package drod_pkg;

   // Field widths fixed by the interface
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;

   // Day numbers from 1 Jan of year 1; any 14-bit year fits in 23 bits
   localparam int DN_W = 23;

   // Number of dates per query: two starts, two ends
   localparam int NUM_DATES = 4;

   // Floor divide by 100 for 14-bit values: (x * 5243) >> 19 is exact
   localparam int CENT_RECIP = 5243;
   localparam int CENT_SHIFT = 19;
   localparam int PROD_W     = 27;
   localparam int CENT_W     = 8;

   localparam int DAYS_PER_YEAR = 365;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [COUNT_W-1:0] OVERLAP_MAX = {COUNT_W{1'b1}};

   typedef logic [DN_W-1:0] dn_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic   ok;
      dn_type dn;
   } date_info_type;

   // Days in a month; February follows the leap flag
   function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] month,
                                            input logic leap_year);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:    len = leap_year ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the year before the first of a month, non-leap
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
      logic [8:0] cnt;
      unique case (month)
         4'd1:    cnt = 9'd0;
         4'd2:    cnt = 9'd31;
         4'd3:    cnt = 9'd59;
         4'd4:    cnt = 9'd90;
         4'd5:    cnt = 9'd120;
         4'd6:    cnt = 9'd151;
         4'd7:    cnt = 9'd181;
         4'd8:    cnt = 9'd212;
         4'd9:    cnt = 9'd243;
         4'd10:   cnt = 9'd273;
         4'd11:   cnt = 9'd304;
         4'd12:   cnt = 9'd334;
         default: cnt = 9'd0;
      endcase
      return cnt;
   endfunction

endpackage

// File: rtl/core/drod_day_number.sv
module drod_day_number #(
   parameter int MAX_YEAR = 9999
) (
   input  drod_pkg::date_type      date,
   output drod_pkg::date_info_type info
);
   import drod_pkg::*;

   logic [PROD_W-1:0] year_prod;
   logic [CENT_W-1:0] year_cent;
   logic [6:0]        year_rem;
   logic              cent_year;
   logic              quad_cent_year;
   logic              leap_year;
   logic [YEAR_W-1:0] year_prev;
   logic [CENT_W-1:0] prev_cent;
   logic [5:0]        prev_quad;
   logic [4:0]        month_days;
   logic              late_month;

   // Century count by reciprocal multiply, then the remainder mod 100
   assign year_prod = PROD_W'(date.year) * PROD_W'(CENT_RECIP);
   assign year_cent = CENT_W'(year_prod >> CENT_SHIFT);
   assign year_rem  = 7'(date.year - YEAR_W'({6'd0, year_cent} * 14'd100));

   // Leap year: 4/100/400 rule
   assign cent_year      = (year_rem == 7'd0);
   assign quad_cent_year = cent_year && (year_cent[1:0] == 2'd0);
   assign leap_year      = ((date.year[1:0] == 2'd0) && !cent_year) || quad_cent_year;

   // Quotients of year-1 follow from those of year
   assign year_prev = date.year - 14'd1;
   assign prev_cent = year_cent - CENT_W'(cent_year);
   assign prev_quad = 6'(year_cent >> 2) - 6'(quad_cent_year);

   assign month_days = month_len(date.month, leap_year);
   assign late_month = (date.month > MONTH_FEB);

   // Validity of the date
   assign info.ok = (date.year != '0) && (int'(date.year) <= MAX_YEAR) &&
                    (date.month != '0) && (date.month <= MONTH_DEC) &&
                    (date.day != '0) && (date.day <= month_days);

   // Day number; meaningless when the date is invalid
   assign info.dn = DN_W'(year_prev) * DN_W'(DAYS_PER_YEAR)
                  + DN_W'(year_prev >> 2)
                  - DN_W'(prev_cent)
                  + DN_W'(prev_quad)
                  + DN_W'(days_before(date.month))
                  + DN_W'(leap_year && late_month)
                  + DN_W'(date.day)
                  - DN_W'(1);

endmodule

// File: rtl/core/date_range_overlap_days_core.sv
// Overlap in days of two Gregorian date ranges, end day excluded. Each query
// passes the input register, the day-number register and the result register
// in that order, and a new query is taken every cycle unless the result is
// stalled; the stages close up bubbles, so req_ready drops only when all three
// hold a query and the result is stalled. Any invalid date or a range that
// starts after its end returns date_error with a count of 0. Years above
// MAX_YEAR are invalid; a count past the 22-bit range saturates.
module date_range_overlap_days_core #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [drod_pkg::DAY_W-1:0]       req_first_start_day,
   input  logic [drod_pkg::MONTH_W-1:0]     req_first_start_month,
   input  logic [drod_pkg::YEAR_W-1:0]      req_first_start_year,
   input  logic [drod_pkg::DAY_W-1:0]       req_first_end_day,
   input  logic [drod_pkg::MONTH_W-1:0]     req_first_end_month,
   input  logic [drod_pkg::YEAR_W-1:0]      req_first_end_year,
   input  logic [drod_pkg::DAY_W-1:0]       req_second_start_day,
   input  logic [drod_pkg::MONTH_W-1:0]     req_second_start_month,
   input  logic [drod_pkg::YEAR_W-1:0]      req_second_start_year,
   input  logic [drod_pkg::DAY_W-1:0]       req_second_end_day,
   input  logic [drod_pkg::MONTH_W-1:0]     req_second_end_month,
   input  logic [drod_pkg::YEAR_W-1:0]      req_second_end_year,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [drod_pkg::COUNT_W-1:0]     rsp_overlap_days,
   output logic                             rsp_date_error
);
   import drod_pkg::*;

   date_type       in_date_ff [NUM_DATES];
   logic           in_valid_ff;
   date_info_type  info [NUM_DATES];
   dn_type         dn_ff [NUM_DATES];
   logic           dn_ok_ff;
   logic           dn_valid_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic           error_ff, error_in;
   logic           out_valid_ff;

   logic           out_load, dn_load, in_load;
   logic           order_bad;
   dn_type         span_lo, span_hi, span;

   // Stage advance: a stage loads when it is empty or its content moves on
   assign out_load  = !out_valid_ff || rsp_ready;
   assign dn_load   = !dn_valid_ff || out_load;
   assign in_load   = !in_valid_ff || dn_load;
   assign req_ready = in_load;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
      if (in_load && req_valid) begin
         in_date_ff[0] <= '{req_first_start_day, req_first_start_month,
                            req_first_start_year};
         in_date_ff[1] <= '{req_first_end_day, req_first_end_month,
                            req_first_end_year};
         in_date_ff[2] <= '{req_second_start_day, req_second_start_month,
                            req_second_start_year};
         in_date_ff[3] <= '{req_second_end_day, req_second_end_month,
                            req_second_end_year};
      end
   end

   // Date to day number, one converter per date
   for (genvar i = 0; i < NUM_DATES; i++) begin : g_conv
      drod_day_number #(.MAX_YEAR(MAX_YEAR)) u_day_number (
         .date (in_date_ff[i]),
         .info (info[i])
      );
   end

   // Day-number register
   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (dn_load) begin
         dn_valid_ff <= in_valid_ff;
      end
      if (dn_load && in_valid_ff) begin
         for (int i = 0; i < NUM_DATES; i++) begin
            dn_ff[i] <= info[i].dn;
         end
         dn_ok_ff <= info[0].ok && info[1].ok && info[2].ok && info[3].ok;
      end
   end

   // Overlap: later start to earlier end, clamped at zero and saturated
   always_comb begin
      order_bad = (dn_ff[0] > dn_ff[1]) || (dn_ff[2] > dn_ff[3]);
      span_lo   = (dn_ff[0] > dn_ff[2]) ? dn_ff[0] : dn_ff[2];
      span_hi   = (dn_ff[1] < dn_ff[3]) ? dn_ff[1] : dn_ff[3];
      span      = (span_hi > span_lo) ? (span_hi - span_lo) : '0;
      error_in  = !dn_ok_ff || order_bad;
      if (error_in) begin
         count_in = '0;
      end else if (span > DN_W'(OVERLAP_MAX)) begin
         count_in = OVERLAP_MAX;
      end else begin
         count_in = span[COUNT_W-1:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= dn_valid_ff;
      end
      if (out_load && dn_valid_ff) begin
         count_ff <= count_in;
         error_ff <= error_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_overlap_days = count_ff;
   assign rsp_date_error   = error_ff;

endmodule

// File: rtl/core/drod_checker.sv
module drod_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [drod_pkg::DAY_W-1:0]   req_first_start_day,
   input logic [drod_pkg::MONTH_W-1:0] req_first_start_month,
   input logic [drod_pkg::YEAR_W-1:0]  req_first_start_year,
   input logic [drod_pkg::DAY_W-1:0]   req_first_end_day,
   input logic [drod_pkg::MONTH_W-1:0] req_first_end_month,
   input logic [drod_pkg::YEAR_W-1:0]  req_first_end_year,
   input logic [drod_pkg::DAY_W-1:0]   req_second_start_day,
   input logic [drod_pkg::MONTH_W-1:0] req_second_start_month,
   input logic [drod_pkg::YEAR_W-1:0]  req_second_start_year,
   input logic [drod_pkg::DAY_W-1:0]   req_second_end_day,
   input logic [drod_pkg::MONTH_W-1:0] req_second_end_month,
   input logic [drod_pkg::YEAR_W-1:0]  req_second_end_year,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [drod_pkg::COUNT_W-1:0] rsp_overlap_days,
   input logic                         rsp_date_error
);
   import drod_pkg::*;

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With no result waiting, the pipeline always has room
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

   // An error result never carries a count
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_date_error |-> rsp_overlap_days == '0)
      else $error("error result with nonzero count");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_overlap_days)
                                  && $stable(rsp_date_error))
      else $error("stalled result changed");

endmodule

bind date_range_overlap_days_core drod_checker u_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_YEAR      = 9999;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_ITEMS  = 450;
   localparam int DRAIN_CYCLES  = 12;
   localparam int SQUEEZE_AT    = 150;
   localparam int SQUEEZE_LEN   = 80;
   localparam int CALM_FROM     = 200;
   localparam int CALM_TO       = 280;
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef struct packed {
      drod_pkg::date_type first_start;
      drod_pkg::date_type first_end;
      drod_pkg::date_type second_start;
      drod_pkg::date_type second_end;
   } span_query_type;

   typedef struct {
      logic [drod_pkg::COUNT_W-1:0] days;
      logic                         err;
   } overlap_result_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   span_query_type req_query = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [drod_pkg::COUNT_W-1:0] rsp_overlap_days;
   logic        rsp_date_error;

   span_query_type     pending_q[$];
   overlap_result_type overlap_q[$];
   overlap_result_type want;

   bit calm         = 1'b0;
   bit squeeze_done = 1'b0;
   int send_idle    = 0;
   int recv_idle    = 0;
   int sent_count   = 0;
   int results_seen = 0;
   int errors       = 0;

   date_range_overlap_days_core #(
      .MAX_YEAR(MAX_YEAR)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_first_start_day    (req_query.first_start.day),
      .req_first_start_month  (req_query.first_start.month),
      .req_first_start_year   (req_query.first_start.year),
      .req_first_end_day      (req_query.first_end.day),
      .req_first_end_month    (req_query.first_end.month),
      .req_first_end_year     (req_query.first_end.year),
      .req_second_start_day   (req_query.second_start.day),
      .req_second_start_month (req_query.second_start.month),
      .req_second_start_year  (req_query.second_start.year),
      .req_second_end_day     (req_query.second_end.day),
      .req_second_end_month   (req_query.second_end.month),
      .req_second_end_year    (req_query.second_end.year),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_overlap_days       (rsp_overlap_days),
      .rsp_date_error         (rsp_date_error)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // Calendar predictor
   // ---------------------------------------------------------------
   function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         drod_pkg::MONTH_FEB:   return is_leap(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic bit date_valid(drod_pkg::date_type dt);
      if (dt.year < 1 || dt.year > MAX_YEAR) return 1'b0;
      if (dt.month < 1 || dt.month > drod_pkg::MONTH_DEC) return 1'b0;
      return (dt.day >= 1) && (dt.day <= month_days(dt.month, dt.year));
   endfunction

   // days since 1 Jan of year 1; only for valid dates
   function automatic int unsigned day_index(drod_pkg::date_type dt);
      int unsigned p;
      int unsigned n;
      p = dt.year - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int unsigned mm = 1; mm < dt.month; mm++)
         n += month_days(mm, dt.year);
      return n + dt.day - 1;
   endfunction

   function automatic overlap_result_type predict_overlap(span_query_type q);
      overlap_result_type r;
      int unsigned s1, e1, s2, e2, lo, hi, cnt;
      r.days = '0;
      r.err  = 1'b1;
      if (!date_valid(q.first_start) || !date_valid(q.first_end) ||
          !date_valid(q.second_start) || !date_valid(q.second_end))
         return r;
      s1 = day_index(q.first_start);
      e1 = day_index(q.first_end);
      s2 = day_index(q.second_start);
      e2 = day_index(q.second_end);
      // a range running backwards is an error
      if (s1 > e1 || s2 > e2) return r;
      lo = (s1 > s2) ? s1 : s2;
      hi = (e1 < e2) ? e1 : e2;
      r.err = 1'b0;
      if (hi > lo) begin
         cnt = hi - lo;
         if (cnt > drod_pkg::OVERLAP_MAX) r.days = drod_pkg::OVERLAP_MAX;
         else r.days = cnt[drod_pkg::COUNT_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic drod_pkg::date_type mk_date(int unsigned d, int unsigned m,
                                                  int unsigned y);
      drod_pkg::date_type dt;
      dt.day   = d[drod_pkg::DAY_W-1:0];
      dt.month = m[drod_pkg::MONTH_W-1:0];
      dt.year  = y[drod_pkg::YEAR_W-1:0];
      return dt;
   endfunction

   function automatic drod_pkg::date_type random_date(int unsigned ylo, int unsigned yhi);
      int unsigned y, m;
      y = $urandom_range(yhi, ylo);
      m = $urandom_range(12, 1);
      return mk_date($urandom_range(month_days(m, y), 1), m, y);
   endfunction

   // mostly short gaps, a few long ones; none during calm stretches
   function automatic int idle_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   task automatic add_query(drod_pkg::date_type a, drod_pkg::date_type b,
                            drod_pkg::date_type c, drod_pkg::date_type d);
      pending_q.push_back({a, b, c, d});
   endtask

   task automatic load_directed();
      // identical ranges over a leap year, and the full calendar span
      add_query(mk_date(1, 1, 2000), mk_date(31, 12, 2000),
                mk_date(1, 1, 2000), mk_date(31, 12, 2000));
      add_query(mk_date(1, 1, 1), mk_date(31, 12, MAX_YEAR),
                mk_date(1, 1, 1), mk_date(31, 12, MAX_YEAR));
      // disjoint, touching on one day, zero-length ranges
      add_query(mk_date(1, 1, 2010), mk_date(10, 1, 2010),
                mk_date(1, 2, 2010), mk_date(10, 2, 2010));
      add_query(mk_date(1, 1, 2010), mk_date(10, 1, 2010),
                mk_date(10, 1, 2010), mk_date(20, 1, 2010));
      add_query(mk_date(5, 5, 1999), mk_date(5, 5, 1999),
                mk_date(5, 5, 1999), mk_date(5, 5, 1999));
      // containment across a leap day, partial overlap with period two first
      add_query(mk_date(1, 1, 2020), mk_date(1, 1, 2021),
                mk_date(15, 2, 2020), mk_date(15, 3, 2020));
      add_query(mk_date(1, 6, 1600), mk_date(1, 6, 1700),
                mk_date(1, 1, 1500), mk_date(1, 1, 1650));
      // backwards ranges
      add_query(mk_date(2, 1, 2000), mk_date(1, 1, 2000),
                mk_date(1, 1, 2000), mk_date(3, 1, 2000));
      add_query(mk_date(1, 1, 2000), mk_date(3, 1, 2000),
                mk_date(1, 1, 2001), mk_date(31, 12, 2000));
      // leap day under the century rules
      add_query(mk_date(29, 2, 2024), mk_date(1, 3, 2024),
                mk_date(1, 2, 2024), mk_date(29, 2, 2024));
      add_query(mk_date(29, 2, 1900), mk_date(1, 3, 1900),
                mk_date(1, 1, 1900), mk_date(1, 1, 1901));
      add_query(mk_date(28, 2, 2000), mk_date(1, 3, 2000),
                mk_date(29, 2, 2000), mk_date(1, 3, 2000));
      add_query(mk_date(1, 1, 2100), mk_date(1, 1, 2101),
                mk_date(29, 2, 2100), mk_date(1, 3, 2100));
      add_query(mk_date(30, 2, 2024), mk_date(1, 3, 2024),
                mk_date(1, 1, 2024), mk_date(1, 1, 2025));
      // bad months, bad days
      add_query(mk_date(1, 0, 2000), mk_date(1, 1, 2001),
                mk_date(1, 1, 2000), mk_date(1, 1, 2001));
      add_query(mk_date(1, 1, 2000), mk_date(1, 13, 2000),
                mk_date(1, 1, 2000), mk_date(1, 1, 2001));
      add_query(mk_date(1, 1, 2000), mk_date(1, 1, 2001),
                mk_date(1, 15, 2000), mk_date(1, 1, 2001));
      add_query(mk_date(1, 1, 2000), mk_date(1, 1, 2001),
                mk_date(1, 1, 2000), mk_date(0, 1, 2001));
      add_query(mk_date(31, 4, 2000), mk_date(1, 5, 2000),
                mk_date(1, 1, 2000), mk_date(31, 12, 2000));
      // bad years, including an all-ones date
      add_query(mk_date(1, 1, 0), mk_date(1, 1, 2),
                mk_date(1, 1, 1), mk_date(1, 1, 2));
      add_query(mk_date(1, 1, 9999), mk_date(1, 1, 10000),
                mk_date(1, 1, 9999), mk_date(31, 12, 9999));
      add_query(mk_date(1, 1, 1), mk_date(31, 15, 16383),
                mk_date(1, 1, 1), mk_date(31, 12, 9999));
   endtask

   task automatic load_random();
      drod_pkg::date_type dts [4];
      drod_pkg::date_type tmp;
      int unsigned kind, span, base, ylo, yhi, sel, raw;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(99);
         span = $urandom_range(3);
         base = $urandom_range(MAX_YEAR, 1);
         case (span)
            0: begin ylo = 1; yhi = MAX_YEAR; end
            1: begin ylo = base; yhi = (base < MAX_YEAR) ? base + 1 : base; end
            2: begin ylo = base; yhi = base; end
            default: begin
               ylo = $urandom_range(1) ? 1 : MAX_YEAR - 1;
               yhi = ylo + 1;
            end
         endcase
         for (int k = 0; k < 4; k++) dts[k] = random_date(ylo, yhi);
         // each range runs forward
         for (int k = 0; k < 4; k += 2)
            if (day_index(dts[k]) > day_index(dts[k+1])) begin
               tmp = dts[k]; dts[k] = dts[k+1]; dts[k+1] = tmp;
            end
         if (kind >= 70 && kind < 80) begin
            // shared boundaries: equal starts, equal ends or touching ranges
            sel = $urandom_range(2);
            if (sel == 0 && day_index(dts[0]) <= day_index(dts[3])) dts[2] = dts[0];
            else if (sel == 1 && day_index(dts[2]) <= day_index(dts[1])) dts[3] = dts[1];
            else if (day_index(dts[1]) <= day_index(dts[3])) dts[2] = dts[1];
         end else if (kind >= 80 && kind < 88) begin
            // one range backwards
            sel = 2 * $urandom_range(1);
            tmp = dts[sel]; dts[sel] = dts[sel+1]; dts[sel+1] = tmp;
         end else if (kind >= 88) begin
            // raw bits in one field
            sel = $urandom_range(3);
            raw = $urandom;
            case ($urandom_range(2))
               0: dts[sel].day   = raw[drod_pkg::DAY_W-1:0];
               1: dts[sel].month = raw[drod_pkg::MONTH_W-1:0];
               default: dts[sel].year = raw[drod_pkg::YEAR_W-1:0];
            endcase
         end
         add_query(dts[0], dts[1], dts[2], dts[3]);
      end
   endtask

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // on a transfer, queue up the answer the block owes
         if (req_valid && req_ready) begin
            overlap_q.push_back(predict_overlap(req_query));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_query <= pending_q.pop_front();
               req_valid <= 1'b1;
               send_idle = idle_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor and checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (overlap_q.size() == 0) begin
               $error("unexpected result transfer: overlap_days %0d date_error %0b",
                      rsp_overlap_days, rsp_date_error);
               errors++;
            end else begin
               want = overlap_q.pop_front();
               if (rsp_overlap_days !== want.days) begin
                  $error("overlap_days: expected %0d, got %0d", want.days, rsp_overlap_days);
                  errors++;
               end
               if (rsp_date_error !== want.err) begin
                  $error("date_error: expected %0b, got %0b", want.err, rsp_date_error);
                  errors++;
               end
            end
         end
         // one long hold-off so the pipeline backs up into the request side
         if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
            squeeze_done = 1'b1;
            recv_idle = SQUEEZE_LEN;
         end
         if (recv_idle > 0) begin
            recv_idle--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_idle = idle_gap();
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence and end of run
   // ---------------------------------------------------------------
   initial begin
      load_directed();
      load_random();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // a stretch with no idling on either side
      while (sent_count < CALM_FROM) @(negedge clock);
      calm = 1'b1;
      while (sent_count < CALM_TO) @(negedge clock);
      calm = 1'b0;
      while (pending_q.size() != 0 || req_valid || overlap_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (overlap_q.size() != 0) begin
         $error("%0d results never arrived", overlap_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/drod_pkg.sv
rtl/core/drod_day_number.sv
rtl/core/date_range_overlap_days_core.sv
rtl/core/drod_checker.sv
tb/sv/testbench.sv
